// ===== hw/rtl/thls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thls_pkg
// Shared types, step codes and saturating Q32.32 helpers for the line solver.
// ----------------------------------------------------------------------------
package thls_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int NODE_W        = 6;
	localparam int CFG_IDX_W     = 1;
	localparam int Q_W           = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_DX2  = 1'd1;

	localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] Q_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

	// sequencer steps
	localparam logic [3:0] STEP_R_MUL = 4'd0;
	localparam logic [3:0] STEP_R_DIV = 4'd1;
	localparam logic [3:0] STEP_X_MUL = 4'd2;
	localparam logic [3:0] STEP_S_MUL = 4'd3;
	localparam logic [3:0] STEP_S_DIV = 4'd4;
	localparam logic [3:0] STEP_COEF  = 4'd5;
	localparam logic [3:0] STEP_D_MUL = 4'd6;
	localparam logic [3:0] STEP_N_MUL = 4'd7;
	localparam logic [3:0] STEP_C_DIV = 4'd8;
	localparam logic [3:0] STEP_P_DIV = 4'd9;
	localparam logic [3:0] STEP_B_RD  = 4'd10;
	localparam logic [3:0] STEP_B_MUL = 4'd11;
	localparam logic [3:0] STEP_NONE  = 4'd15;

	typedef struct packed {
		logic [62:0]        vol_heat_cap;
		logic [62:0]        conductivity;
		logic signed [63:0] old_temperature;
		logic signed [63:0] cross_neighbour_sum;
		logic signed [63:0] heat_source;
		logic               last_node;
	} in_item_t;

	typedef struct packed {
		logic [NODE_W-1:0]  node_index;
		logic signed [63:0] new_temperature;
		logic               divide_fault;
		logic               final_result;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic [3:0] step;
		logic       start;
		logic       commit;
		logic       emit;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic n_zero;
		logic last;
		logic idx_zero;
		logic out_free;
	} sts_t;

	function automatic logic [63:0] mag(input logic signed [63:0] x);
		mag = x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic signed [63:0] from_sm(input logic neg, input logic [63:0] m);
		if (neg)
			from_sm = m[63] ? Q_MIN : (~m + 64'd1);
		else
			from_sm = m[63] ? Q_MAX : m;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			sat_add = s[64] ? Q_MIN : Q_MAX;
		else
			sat_add = s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			sat_sub = s[64] ? Q_MIN : Q_MAX;
		else
			sat_sub = s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
		sat_neg = (a == Q_MIN) ? Q_MAX : (~a + 64'd1);
	endfunction

endpackage

// ===== hw/rtl/tridiagonal_heat_line_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_heat_line_solver
// Thomas-algorithm solver for one line of a semi-implicit heat sweep, Q32.32.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    in_data  (one node of the line)
//  out      out_valid / out_ready  out_data (one solved node, last index first)
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (0: dt, 1: dt/dx^2)
//
// A node runs through five multiplies (three for the first node of a line)
// and four divides on one shared multiplier and one bit-serial divider,
// plus sequencing. On the last node, back-substitution gives out one item
// at a time, each after one RAM read and one multiply. in_ready is high only
// while idle.
// Reset clears the sequencer, node count and fault flag; the coefficient
// RAMs hold no reset and are always written before they are read.
// A stalled output holds its item; the solver waits on it.
module tridiagonal_heat_line_solver #(
	parameter int MAX_NODES = thls_pkg::MAX_NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  thls_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output thls_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [thls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);
	import thls_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// register writes are taken every cycle
	assign cfg_ready = 1'b1;

	thls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	thls_dp #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
		.cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

// ===== hw/rtl/thls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thls_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module thls_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/thls_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thls_mul
// Q32.32 saturating multiply, four 32x32 partial products one after another.
// ----------------------------------------------------------------------------
module thls_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] res
);
	import thls_pkg::*;

	logic [63:0]  x_q, y_q;
	logic         neg_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  prod_q;
	logic [127:0] acc_q;
	logic signed [63:0] res_q;
	logic [31:0]  xs, ys;
	logic [1:0]   pc;
	logic [127:0] addend;
	logic [63:0]  m;

	assign xs = cnt_q[1] ? x_q[63:32] : x_q[31:0];
	assign ys = cnt_q[0] ? y_q[63:32] : y_q[31:0];
	assign pc = 2'(cnt_q - 3'd1);

	always_comb begin
		case (pc)
			2'd0:    addend = {64'd0, prod_q};
			2'd3:    addend = {prod_q, 64'd0};
			default: addend = {32'd0, prod_q, 32'd0};
		endcase
	end

	assign m = (acc_q[127:96] != 32'd0) ? {64{1'b1}} : acc_q[95:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= mag(a);
			y_q   <= mag(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4)
				prod_q <= 64'(xs) * 64'(ys);
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + addend;
			if (cnt_q == 3'd5)
				res_q <= from_sm(neg_q, m);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== hw/rtl/thls_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thls_div
// Q32.32 saturating divide, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module thls_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] n,
	input  logic signed [63:0] d,
	output logic               done,
	output logic               zero,
	output logic signed [63:0] res
);
	import thls_pkg::*;

	logic [63:0] x, y;
	logic [63:0] rem_q, lo_q, y_q, q_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q, fin_q, done_q, zero_q;
	logic signed [63:0] res_q;
	logic [63:0] rem_sh;
	logic        take;

	assign x      = mag(n);
	assign y      = mag(d);
	assign rem_sh = {rem_q[62:0], lo_q[63]};
	assign take   = rem_q[63] || (rem_sh >= y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			zero_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (y == 64'd0) begin
					done_q <= 1'b1;
					zero_q <= 1'b1;
				end else if ({32'd0, x[63:32]} >= y)
					fin_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {32'd0, x[63:32]};
			lo_q  <= {x[31:0], 32'd0};
			y_q   <= y;
			neg_q <= n[63] ^ d[63];
			q_q   <= ({32'd0, x[63:32]} >= y) ? {64{1'b1}} : 64'd0;
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - y_q) : rem_sh;
			lo_q  <= {lo_q[62:0], 1'b0};
			q_q   <= {q_q[62:0], take};
		end else if (fin_q)
			res_q <= from_sm(neg_q, q_q);
	end

	assign done = done_q;
	assign zero = zero_q;
	assign res  = res_q;

endmodule

// ===== hw/rtl/thls_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thls_dp
// Datapath: operand registers, coefficient stores, arithmetic units, output.
// ----------------------------------------------------------------------------
module thls_dp #(
	parameter int MAX_NODES = thls_pkg::MAX_NODES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  thls_pkg::cmd_t                   cmd,
	output thls_pkg::sts_t                   sts,
	input  thls_pkg::in_item_t               in_data,
	input  logic                             cfg_we,
	input  logic [thls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                      cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output thls_pkg::out_item_t              out_data
);
	import thls_pkg::*;

	localparam int IDX_W = $clog2(MAX_NODES);

	logic [62:0] ts_q, sos_q;
	in_item_t    in_q;
	logic [IDX_W-1:0] n_q, idx_q, rd_addr_q;
	logic        last_q, fault_q;
	logic signed [63:0] r_q, rhs_q, tmp_q, a_q, c_q, denom_q, num_q, cp_q, t_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        mul_start, div_start, mul_done, div_done, div_zero;
	logic signed [63:0] mul_a, mul_b, mul_res, div_n, div_d, div_res;
	logic signed [63:0] ram_f, ram_v;
	logic        ram_we;
	logic        out_free;

	// operand routing by step
	always_comb begin
		mul_a = r_q;
		mul_b = in_q.cross_neighbour_sum;
		div_n = tmp_q;
		div_d = {1'b0, in_q.vol_heat_cap};
		case (cmd.step)
			STEP_R_MUL: begin
				mul_a = {1'b0, in_q.conductivity};
				mul_b = {1'b0, sos_q};
			end
			STEP_S_MUL: begin
				mul_a = in_q.heat_source;
				mul_b = {1'b0, ts_q};
			end
			STEP_D_MUL: begin
				mul_a = a_q;
				mul_b = ram_f;
			end
			STEP_N_MUL: begin
				mul_a = a_q;
				mul_b = ram_v;
			end
			STEP_B_MUL: begin
				mul_a = ram_f;
				mul_b = t_q;
			end
			STEP_C_DIV: begin
				div_n = c_q;
				div_d = denom_q;
			end
			STEP_P_DIV: begin
				div_n = num_q;
				div_d = denom_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_start = cmd.start && (cmd.step inside {STEP_R_MUL, STEP_X_MUL, STEP_S_MUL,
		STEP_D_MUL, STEP_N_MUL, STEP_B_MUL});
	assign div_start = cmd.start && (cmd.step inside {STEP_R_DIV, STEP_S_DIV,
		STEP_C_DIV, STEP_P_DIV});
	assign ram_we    = cmd.commit && (cmd.step == STEP_P_DIV);
	assign out_free  = !out_valid_q || out_ready;

	thls_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .res(mul_res)
	);

	thls_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(div_n), .d(div_d),
		.done(div_done), .zero(div_zero), .res(div_res)
	);

	thls_ram #(.WIDTH(Q_W), .DEPTH(MAX_NODES)) u_factor_ram (
		.clk(clk), .we(ram_we), .waddr(n_q), .wdata(cp_q),
		.raddr(rd_addr_q), .rdata(ram_f)
	);

	thls_ram #(.WIDTH(Q_W), .DEPTH(MAX_NODES)) u_value_ram (
		.clk(clk), .we(ram_we), .waddr(n_q), .wdata(div_res),
		.raddr(rd_addr_q), .rdata(ram_v)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q        <= '0;
			sos_q       <= '0;
			n_q         <= '0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIME_STEP: ts_q  <= cfg_data[62:0];
					CFG_STEP_DX2:  sos_q <= cfg_data[62:0];
					default: begin
					end
				endcase
			end
			if (div_done && div_zero)
				fault_q <= 1'b1;
			if (cmd.finish)
				fault_q <= 1'b0;
			if (cmd.commit && cmd.step == STEP_P_DIV)
				n_q <= last_q ? '0 : n_q + IDX_W'(1);
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q   <= in_data;
			last_q <= in_data.last_node || (n_q == IDX_W'(MAX_NODES - 1));
		end
		if (cmd.commit) begin
			case (cmd.step)
				STEP_R_MUL: tmp_q <= mul_res;
				STEP_R_DIV: r_q   <= div_res;
				STEP_X_MUL: rhs_q <= sat_add(in_q.old_temperature, mul_res);
				STEP_S_MUL: tmp_q <= mul_res;
				STEP_S_DIV: rhs_q <= sat_add(rhs_q, div_res);
				STEP_COEF: begin
					a_q       <= (n_q == '0) ? '0 : sat_neg(r_q);
					c_q       <= last_q ? '0 : sat_neg(r_q);
					denom_q   <= sat_add(Q_ONE, sat_add(r_q, r_q));
					num_q     <= rhs_q;
					rd_addr_q <= n_q - IDX_W'(1);
				end
				STEP_D_MUL: denom_q <= sat_sub(denom_q, mul_res);
				STEP_N_MUL: num_q   <= sat_sub(num_q, mul_res);
				STEP_C_DIV: cp_q    <= div_res;
				STEP_P_DIV: begin
					t_q   <= div_res;
					idx_q <= n_q;
				end
				STEP_B_RD: begin
					idx_q     <= idx_q - IDX_W'(1);
					rd_addr_q <= idx_q - IDX_W'(1);
				end
				STEP_B_MUL: t_q <= sat_sub(ram_v, mul_res);
				default: begin
				end
			endcase
		end
		if (cmd.emit) begin
			out_q.node_index      <= NODE_W'(idx_q);
			out_q.new_temperature <= t_q;
			out_q.divide_fault    <= fault_q;
			out_q.final_result    <= (idx_q == '0);
		end
	end

	assign sts.done     = mul_done || div_done;
	assign sts.n_zero   = (n_q == '0);
	assign sts.last     = last_q;
	assign sts.idx_zero = (idx_q == '0);
	assign sts.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/thls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thls_ctrl
// Sequencer: steps each node through elimination, then back-substitution after the last node.
// ----------------------------------------------------------------------------
module thls_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  thls_pkg::sts_t sts,
	output thls_pkg::cmd_t cmd
);
	import thls_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RUN   = 3'd1;
	localparam logic [2:0] S_COEF  = 3'd2;
	localparam logic [2:0] S_RWAIT = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_BRD   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [3:0] step_q, step_d;
	logic       wait_q, wait_d;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		wait_d  = wait_q;
		cmd     = '0;
		cmd.step = STEP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
					step_d   = STEP_R_MUL;
				end
			end
			S_RUN: begin
				cmd.step = step_q;
				if (!wait_q) begin
					cmd.start = 1'b1;
					wait_d    = 1'b1;
				end else if (sts.done) begin
					cmd.commit = 1'b1;
					wait_d     = 1'b0;
					case (step_q)
						STEP_R_MUL: step_d  = STEP_R_DIV;
						STEP_R_DIV: step_d  = STEP_X_MUL;
						STEP_X_MUL: step_d  = STEP_S_MUL;
						STEP_S_MUL: step_d  = STEP_S_DIV;
						STEP_S_DIV: state_d = S_COEF;
						STEP_D_MUL: step_d  = STEP_N_MUL;
						STEP_N_MUL: step_d  = STEP_C_DIV;
						STEP_C_DIV: step_d  = STEP_P_DIV;
						STEP_P_DIV: state_d = sts.last ? S_EMIT : S_IDLE;
						STEP_B_MUL: state_d = S_EMIT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_COEF: begin
				cmd.step   = STEP_COEF;
				cmd.commit = 1'b1;
				if (sts.n_zero) begin
					state_d = S_RUN;
					step_d  = STEP_C_DIV;
				end else begin
					state_d = S_RWAIT;
					step_d  = STEP_D_MUL;
				end
			end
			S_RWAIT: state_d = S_RUN;
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.idx_zero) begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end else
						state_d = S_BRD;
				end
			end
			S_BRD: begin
				cmd.step   = STEP_B_RD;
				cmd.commit = 1'b1;
				state_d    = S_RWAIT;
				step_d     = STEP_B_MUL;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= STEP_NONE;
			wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			wait_q  <= wait_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ===== hw/rtl/thls_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thls_chk
// Port-level checks on the line solver, bound to the top level.
// ----------------------------------------------------------------------------
module thls_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input thls_pkg::in_item_t             in_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input thls_pkg::out_item_t            out_data,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [thls_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [63:0]                    cfg_data
);
	import thls_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input item changed while waiting");

	a_one_node: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second node taken while one is in work");

	a_final_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.final_result == (out_data.node_index == '0)))
		else $error("final flag disagrees with node index");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
		else $error("register port not ready or write undefined");

endmodule

bind tridiagonal_heat_line_solver thls_chk u_thls_chk (.*);
